// ----- rtl/core/address_range_group_match_defines.svh -----
// Assertion macros shared by the address range matcher. They expand to nothing
// when the design is read for synthesis.
`ifndef ADDRESS_RANGE_GROUP_MATCH_DEFINES_SVH
`define ADDRESS_RANGE_GROUP_MATCH_DEFINES_SVH
`ifndef SYNTHESIS
// Checked at every rising edge outside reset.
`define ARGM_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every rising edge, reset included.
`define ARGM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ARGM_ASSERT(lbl, clk, rst_n, prop, msg)
`define ARGM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- rtl/core/argm_pkg.sv -----
package argm_pkg;

	localparam int unsigned ENTRIES_DEF = 16;

	localparam int unsigned MODE_W = 2;
	localparam int unsigned SLOT_W = 4;
	localparam int unsigned HALF_W = 64;
	localparam int unsigned ADDR_W = 2 * HALF_W;
	localparam int unsigned V4_W   = 32;

	// Command codes as they arrive on the mode field.
	localparam logic [MODE_W-1:0] MODE_WRITE  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

	// Operation kinds after the front end has checked the slot range.
	localparam int unsigned KIND_W = 2;
	localparam logic [KIND_W-1:0] OP_NONE   = 2'd0;
	localparam logic [KIND_W-1:0] OP_WRITE  = 2'd1;
	localparam logic [KIND_W-1:0] OP_DELETE = 2'd2;
	localparam logic [KIND_W-1:0] OP_QUERY  = 2'd3;

	// Command queue between the front and back ends.
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = 1;
	localparam int unsigned QCNT_W      = 2;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [SLOT_W-1:0] slot;
		logic              ipv6;
		logic [ADDR_W-1:0] addr;
		logic [ADDR_W-1:0] bound;
	} op_t;

endpackage

// ----- rtl/core/argm_front.sv -----
`include "address_range_group_match_defines.svh"

module argm_front #(
	parameter int unsigned ENTRIES = argm_pkg::ENTRIES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [argm_pkg::MODE_W-1:0] mode,
	input  logic [argm_pkg::SLOT_W-1:0] slot,
	input  logic                        is_ipv6,
	input  logic [argm_pkg::HALF_W-1:0] addr_hi,
	input  logic [argm_pkg::HALF_W-1:0] addr_lo,
	input  logic [argm_pkg::HALF_W-1:0] bound_hi,
	input  logic [argm_pkg::HALF_W-1:0] bound_lo,
	output logic                        q_valid,
	output argm_pkg::op_t               q_op,
	input  logic                        q_pop
);
	import argm_pkg::*;

	op_t               queue_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              push;
	logic              slot_ok;
	op_t               new_op;

	// Writes and deletes aimed past the table are turned into no-ops here.
	assign slot_ok = (32'(slot) < ENTRIES);

	always_comb begin
		new_op.slot  = slot;
		new_op.ipv6  = is_ipv6;
		new_op.addr  = {addr_hi, addr_lo};
		new_op.bound = {bound_hi, bound_lo};
		unique case (mode)
			MODE_WRITE:  new_op.kind = slot_ok ? OP_WRITE : OP_NONE;
			MODE_DELETE: new_op.kind = slot_ok ? OP_DELETE : OP_NONE;
			MODE_QUERY:  new_op.kind = OP_QUERY;
			default:     new_op.kind = OP_NONE;
		endcase
	end

	assign in_stall = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign push     = in_valid && !in_stall;
	assign q_valid  = (count_q != '0);
	assign q_op     = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= new_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !q_pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (!push && q_pop) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	`ARGM_ASSERT_ALWAYS(a_queue_bound, clk, count_q <= QCNT_W'(QUEUE_DEPTH), "command queue overfilled")
	`ARGM_ASSERT(a_pop_nonempty, clk, arst_n, q_pop |-> count_q != '0, "pop from an empty command queue")

endmodule

// ----- rtl/core/argm_back.sv -----
`include "address_range_group_match_defines.svh"

module argm_back #(
	parameter int unsigned ENTRIES = argm_pkg::ENTRIES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	input  argm_pkg::op_t               q_op,
	output logic                        q_pop,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        matched,
	output logic [argm_pkg::SLOT_W-1:0] match_slot
);
	import argm_pkg::*;

	localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	typedef struct packed {
		logic              ipv6;
		logic [ADDR_W-1:0] low;
		logic [ADDR_W-1:0] high;
	} entry_t;

	entry_t             entry_mem [ENTRIES];
	logic [ENTRIES-1:0] valid_q;

	logic [1:0]        state_q;
	logic [IDX_W-1:0]  scan_idx_q;
	logic              issuing_q;
	logic              qv6_q;
	logic [ADDR_W-1:0] qaddr_q;
	logic              found_q;
	logic [SLOT_W-1:0] found_slot_q;

	entry_t            rd_entry_s1;
	logic              rd_valid_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic              last_s1;
	logic              live_s1;

	logic              out_valid_q;
	logic              matched_q;
	logic [SLOT_W-1:0] match_slot_q;

	logic              out_free;
	logic [IDX_W-1:0]  op_idx;
	logic              scan_last;
	logic              in_range;
	logic              hit_s1;
	logic              done_s1;
	logic              load_out;
	logic              load_matched;
	logic [SLOT_W-1:0] load_slot;

	assign out_free  = !out_valid_q || !out_stall;
	assign q_pop     = (state_q == ST_IDLE) && q_valid && out_free;
	assign op_idx    = IDX_W'(q_op.slot);
	assign scan_last = (scan_idx_q == IDX_W'(ENTRIES - 1));

	always_comb begin
		if (qv6_q) begin
			in_range = !(rd_entry_s1.low > qaddr_q) && !(qaddr_q > rd_entry_s1.high);
		end else begin
			in_range = !(rd_entry_s1.low[V4_W-1:0] > qaddr_q[V4_W-1:0]) &&
				!(qaddr_q[V4_W-1:0] > rd_entry_s1.high[V4_W-1:0]);
		end
	end

	assign hit_s1  = (state_q == ST_SCAN) && live_s1 && rd_valid_s1 &&
		(rd_entry_s1.ipv6 == qv6_q) && in_range;
	assign done_s1 = (state_q == ST_SCAN) && live_s1 && (hit_s1 || last_s1);

	always_comb begin
		load_out     = 1'b0;
		load_matched = 1'b0;
		load_slot    = '0;
		if (q_pop && (q_op.kind != OP_QUERY)) begin
			load_out = 1'b1;
		end else if ((state_q == ST_DONE) && out_free) begin
			load_out     = 1'b1;
			load_matched = found_q;
			load_slot    = found_slot_q;
		end
	end

	// Entry storage: one write port for commands, one registered read port for the scan.
	always_ff @(posedge clk) begin
		if (q_pop && (q_op.kind == OP_WRITE)) begin
			entry_mem[op_idx] <= '{ipv6: q_op.ipv6, low: q_op.addr, high: q_op.bound};
		end
		rd_entry_s1 <= entry_mem[scan_idx_q];
		idx_s1      <= scan_idx_q;
	end

	always_ff @(posedge clk) begin
		if (q_pop && (q_op.kind == OP_QUERY)) begin
			qv6_q   <= q_op.ipv6;
			qaddr_q <= q_op.addr;
		end
		if (load_out) begin
			matched_q    <= load_matched;
			match_slot_q <= load_slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			state_q      <= ST_IDLE;
			scan_idx_q   <= '0;
			issuing_q    <= 1'b0;
			found_q      <= 1'b0;
			found_slot_q <= '0;
			rd_valid_s1  <= 1'b0;
			last_s1      <= 1'b0;
			live_s1      <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			rd_valid_s1 <= valid_q[scan_idx_q];
			last_s1     <= scan_last;
			live_s1     <= (state_q == ST_SCAN) && issuing_q && !done_s1;

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						unique case (q_op.kind)
							OP_WRITE:  valid_q[op_idx] <= 1'b1;
							OP_DELETE: valid_q[op_idx] <= 1'b0;
							OP_QUERY: begin
								scan_idx_q <= '0;
								issuing_q  <= 1'b1;
								state_q    <= ST_SCAN;
							end
							default: ;
						endcase
					end
				end
				ST_SCAN: begin
					if (issuing_q) begin
						if (scan_last) begin
							issuing_q <= 1'b0;
						end else begin
							scan_idx_q <= scan_idx_q + IDX_W'(1);
						end
					end
					if (done_s1) begin
						found_q      <= hit_s1;
						found_slot_q <= hit_s1 ? SLOT_W'(idx_s1) : '0;
						issuing_q    <= 1'b0;
						state_q      <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign matched    = matched_q;
	assign match_slot = match_slot_q;

	`ARGM_ASSERT(a_idle_no_compare, clk, arst_n, state_q == ST_IDLE |-> !live_s1, "compare stage live while idle")
	`ARGM_ASSERT(a_scan_out_empty, clk, arst_n, state_q == ST_SCAN |-> !out_valid_q, "scan running while a result waits")
	`ARGM_ASSERT(a_hit_is_valid, clk, arst_n, (out_valid_q && matched_q) |-> valid_q[IDX_W'(match_slot_q)], "reported slot is not valid")

endmodule

// ----- rtl/core/address_range_group_match.sv -----
// Address range matcher. The block keeps a table of ENTRIES address ranges, each
// with a valid mark, an IPv4/IPv6 tag and inclusive 128-bit lower and upper
// bounds. A word with mode 0 writes the range at the given slot (addr_hi/addr_lo
// is the lower bound, bound_hi/bound_lo the upper bound), mode 1 deletes that
// slot, and mode 2 looks up the address in addr_hi/addr_lo: the result reports
// the lowest valid slot of the same family whose range holds the address, as
// unsigned numbers; IPv4 compares only the low 32 bits of addr_lo and of the
// bounds. Every input word yields exactly one result word; writes, deletes,
// unused mode 3 and misses report matched = 0 and match_slot = 0, and writes or
// deletes to a slot beyond the table are ignored. A two-word command queue sits
// behind the input, so the input can take up to two more words while a lookup
// runs or a result is stalled. A lookup reads the table through its single read
// port one entry per cycle and stops at the first hit, so it holds the execution
// unit until its result is loaded into the output register.
// The valid marks clear at reset; no clearing pass is needed.
module address_range_group_match #(
	parameter int unsigned ENTRIES = argm_pkg::ENTRIES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [argm_pkg::MODE_W-1:0] mode,
	input  logic [argm_pkg::SLOT_W-1:0] slot,
	input  logic                        is_ipv6,
	input  logic [argm_pkg::HALF_W-1:0] addr_hi,
	input  logic [argm_pkg::HALF_W-1:0] addr_lo,
	input  logic [argm_pkg::HALF_W-1:0] bound_hi,
	input  logic [argm_pkg::HALF_W-1:0] bound_lo,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        matched,
	output logic [argm_pkg::SLOT_W-1:0] match_slot
);
	import argm_pkg::*;

	// Decoded commands travel from the front end to the execution unit.
	logic q_valid;
	op_t  q_op;
	logic q_pop;

	argm_front #(
		.ENTRIES (ENTRIES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.mode     (mode),
		.slot     (slot),
		.is_ipv6  (is_ipv6),
		.addr_hi  (addr_hi),
		.addr_lo  (addr_lo),
		.bound_hi (bound_hi),
		.bound_lo (bound_lo),
		.q_valid  (q_valid),
		.q_op     (q_op),
		.q_pop    (q_pop)
	);

	// The execution unit owns the table, runs the scan and holds the output register.
	argm_back #(
		.ENTRIES (ENTRIES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_op       (q_op),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.matched    (matched),
		.match_slot (match_slot)
	);

endmodule
